>>> rtl/rog_pkg.sv
`timescale 1ns / 1ps

package rog_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_RECENTER = 2'd0,
    REQ_HIT      = 2'd1,
    REQ_DECAY    = 2'd2,
    REQ_READ     = 2'd3
  } req_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_e;

  // One grid cell as stored in memory.
  typedef struct packed {
    logic       occ;
    logic [7:0] stale;
    logic       touched;
  } cell_t;

  localparam int unsigned CellW = $bits(cell_t);

  // Staleness limits.
  localparam logic [7:0] StaleShiftCap = 8'd254;
  localparam logic [7:0] StaleMax      = 8'd255;
  localparam logic [7:0] StaleLimRst   = 8'd10;

endpackage

>>> rtl/rog_ram.sv
`timescale 1ns / 1ps

module rog_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rolling_occupancy_grid_decay.sv
`timescale 1ns / 1ps

// Rolling-window occupancy grid with staleness decay.
// Input beats (req_type_i, cell_x_i, cell_y_i) arrive on a valid/ready
// channel; each one yields exactly one output beat (in_window_o,
// occupied_o, stale_count_o) on a second valid/ready channel.
// The staleness limit is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle, which the block does not enforce.
// Hit and read beats: the memory read is registered at the accepting edge,
// S_CELL writes the cell on a hit and loads the result register, and S_DONE
// loads the output register. Recenter and decay sweep every cell once
// through a pair of ping-pong cell memories, the sweep walking one cell per
// cycle in S_SWEEP, followed by S_DRAIN and S_DONE. A decay before the first
// recenter skips the sweep and goes from S_IDLE straight to S_DONE. One beat
// is in work at a time.
// Reset clears the control state, sets the staleness limit to 10 and marks
// the grid not ready; the memories are not cleared, since the first recenter
// rewrites every cell. The output register lets the next input beat be
// accepted while a result waits; if the receiver stalls longer, the block
// holds its finished result and stops taking input.
module rolling_occupancy_grid_decay #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [15:0] cell_x_i,
  input  logic signed [15:0] cell_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        in_window_o,
  output logic        occupied_o,
  output logic [7:0]  stale_count_o
);

  import rog_pkg::*;

  localparam int unsigned NCells = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW = (NCells > 1) ? $clog2(NCells) : 1;
  localparam int unsigned CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam logic signed [16:0] ColsN = 17'(GRID_COLS);
  localparam logic signed [16:0] RowsN = 17'(GRID_ROWS);
  localparam logic signed [18:0] ColsW = 19'(GRID_COLS);
  localparam logic signed [18:0] RowsW = 19'(GRID_ROWS);
  localparam logic [AW-1:0] LastCell = AW'(NCells - 1);
  localparam logic [CW-1:0] LastCol = CW'(GRID_COLS - 1);

  state_e state_q, state_d;
  req_e   req_q;
  logic   accept;
  logic   bank_q, grid_ready_q;
  logic signed [15:0] orig_col_q, orig_row_q, nx_q, ny_q;
  logic signed [16:0] dx_q, dy_q;
  logic [7:0] stale_lim_q, limit;
  logic [CW-1:0] ci_q;
  logic [RW-1:0] cj_q;
  logic [AW-1:0] k_q, wr_addr_q, idx_q;
  logic       wr_pend_q, src_ok_q, inwin_q;
  logic       res_win_q, res_occ_q;
  logic [7:0] res_stale_q;
  logic       out_valid_q, out_win_q, out_occ_q;
  logic [7:0] out_stale_q;

  // Locating a hit or read cell relative to the origin.
  logic signed [16:0] di, dj;
  logic               loc_ok;
  logic [AW-1:0]      loc_idx;

  assign di = 17'(cell_x_i) - 17'(orig_col_q);
  assign dj = 17'(cell_y_i) - 17'(orig_row_q);
  assign loc_ok = grid_ready_q && !di[16] && (di < ColsN) && !dj[16] && (dj < RowsN);
  assign loc_idx = AW'(di[CW-1:0]) + AW'(dj[RW-1:0]) * AW'(GRID_COLS);

  // Source cell of the sweep: shifted cell for recenter, same cell for decay.
  logic signed [18:0] si, sj;
  logic               src_ok;
  logic [AW-1:0]      src_addr;

  assign si = $signed(19'(ci_q)) + 19'(dx_q);
  assign sj = $signed(19'(cj_q)) + 19'(dy_q);

  always_comb begin
    if (req_q == REQ_RECENTER) begin
      src_ok   = grid_ready_q && !si[18] && (si < ColsW) && !sj[18] && (sj < RowsW);
      src_addr = AW'(si[CW-1:0]) + AW'(sj[RW-1:0]) * AW'(GRID_COLS);
    end else begin
      src_ok   = 1'b1;
      src_addr = k_q;
    end
  end

  // Memory ports: both banks read at one address; the active bank is used.
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [CellW-1:0] rdata0, rdata1, wdata;
  logic             we0, we1, cell_we, sweep_we;
  cell_t            rd_cell, sweep_cell;

  assign rd_addr = (state_q == S_SWEEP) ? src_addr : loc_idx;
  assign rd_cell = cell_t'(bank_q ? rdata1 : rdata0);
  assign limit   = (stale_lim_q == 8'd0) ? 8'd1 : stale_lim_q;

  // New cell value for the sweep write stage.
  always_comb begin
    logic [7:0] inc;
    inc        = 8'd0;
    sweep_cell = rd_cell;
    if (req_q == REQ_RECENTER) begin
      sweep_cell = '0;
      if (src_ok_q && rd_cell.occ) begin
        sweep_cell.occ   = 1'b1;
        sweep_cell.stale = (rd_cell.stale < StaleShiftCap) ? rd_cell.stale + 8'd1
                                                           : StaleShiftCap;
      end
    end else if (rd_cell.occ) begin
      if (rd_cell.touched) begin
        sweep_cell.stale = 8'd0;
      end else begin
        inc = (rd_cell.stale != StaleMax) ? rd_cell.stale + 8'd1 : StaleMax;
        sweep_cell.stale = inc;
        if (inc > limit) begin
          sweep_cell.occ = 1'b0;
        end
      end
    end
  end

  // Hits write the active bank; sweeps write the other one.
  assign cell_we  = (state_q == S_CELL) && (req_q == REQ_HIT) && inwin_q;
  assign sweep_we = wr_pend_q;
  assign we0      = (cell_we && !bank_q) || (sweep_we && bank_q);
  assign we1      = (cell_we && bank_q) || (sweep_we && !bank_q);
  assign wr_addr  = sweep_we ? wr_addr_q : idx_q;
  assign wdata    = sweep_we ? CellW'(sweep_cell) : CellW'(cell_t'{1'b1, 8'd0, 1'b1});

  rog_ram #(.Width(CellW), .Depth(NCells)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  rog_ram #(.Width(CellW), .Depth(NCells)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_RECENTER: state_d = S_SWEEP;
            REQ_DECAY:    state_d = grid_ready_q ? S_SWEEP : S_DONE;
            default:      state_d = S_CELL;
          endcase
        end
      end
      S_CELL:  state_d = S_DONE;
      S_SWEEP: state_d = (k_q == LastCell) ? S_DRAIN : S_SWEEP;
      S_DRAIN: state_d = S_DONE;
      S_DONE:  state_d = (!out_valid_q || out_ready_i) ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bank_q       <= 1'b0;
      grid_ready_q <= 1'b0;
      orig_col_q   <= '0;
      orig_row_q   <= '0;
      stale_lim_q  <= StaleLimRst;
      wr_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= (state_q == S_SWEEP);
      if (cfg_we_i) begin
        stale_lim_q <= cfg_wdata_i;
      end
      // The sweep ends: switch banks and commit a new origin.
      if (state_q == S_DRAIN) begin
        bank_q <= !bank_q;
        if (req_q == REQ_RECENTER) begin
          grid_ready_q <= 1'b1;
          orig_col_q   <= nx_q;
          orig_row_q   <= ny_q;
        end
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= req_e'(req_type_i);
      nx_q        <= cell_x_i;
      ny_q        <= cell_y_i;
      dx_q        <= 17'(cell_x_i) - 17'(orig_col_q);
      dy_q        <= 17'(cell_y_i) - 17'(orig_row_q);
      inwin_q     <= loc_ok;
      idx_q       <= loc_idx;
      ci_q        <= '0;
      cj_q        <= '0;
      k_q         <= '0;
      res_win_q   <= 1'b0;
      res_occ_q   <= 1'b0;
      res_stale_q <= 8'd0;
    end
    // Walk the grid one cell per cycle.
    if (state_q == S_SWEEP) begin
      wr_addr_q <= k_q;
      src_ok_q  <= src_ok;
      k_q       <= k_q + AW'(1);
      if (ci_q == LastCol) begin
        ci_q <= '0;
        cj_q <= cj_q + RW'(1);
      end else begin
        ci_q <= ci_q + CW'(1);
      end
    end
    if (state_q == S_CELL && inwin_q) begin
      res_win_q   <= 1'b1;
      res_occ_q   <= (req_q == REQ_HIT) ? 1'b1 : rd_cell.occ;
      res_stale_q <= (req_q == REQ_HIT) ? 8'd0 : rd_cell.stale;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_win_q   <= res_win_q;
      out_occ_q   <= res_occ_q;
      out_stale_q <= res_stale_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign in_window_o   = out_win_q;
  assign occupied_o    = out_occ_q;
  assign stale_count_o = out_stale_q;

`ifndef SYNTHESIS
  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we0 && we1))
    else $error("both cell banks written in one cycle");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while a beat is in work");

  a_sweep_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_SWEEP || state_q == S_DRAIN))
    else $error("sweep write outside a sweep");

  a_no_hit_before_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_we |-> grid_ready_q)
    else $error("cell written before the first recenter");

  a_drain_flips_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (bank_q != $past(bank_q)))
    else $error("bank not switched after a sweep");
`endif

endmodule

>>> sim/rolling_occupancy_grid_decay_tb.sv
`timescale 1ns / 1ps

module rolling_occupancy_grid_decay_tb;
  import rog_pkg::*;

  localparam int Cols = 64;
  localparam int Rows = 64;
  localparam int NumCells = Cols * Rows;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic       in_window;
    logic       occupied;
    logic [7:0] stale_count;
  } cell_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic signed [15:0] cell_x_i;
  logic signed [15:0] cell_y_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        in_window_o;
  logic        occupied_o;
  logic [7:0]  stale_count_o;

  // Shadow grid state.
  logic       grid_occ [NumCells];
  logic [7:0] grid_stale [NumCells];
  logic       grid_touch [NumCells];
  int         win_col;
  int         win_row;
  logic       win_ready;
  logic [7:0] stale_limit;

  cell_report_t pending_reports[$];
  int          fail_count;
  int          burst_left;
  int          hold_left;
  bit          hold_req;
  int          idle_cycles;

  rolling_occupancy_grid_decay #(
    .GRID_COLS(Cols),
    .GRID_ROWS(Rows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_window_o  (in_window_o),
    .occupied_o   (occupied_o),
    .stale_count_o(stale_count_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted beat to the shadow grid and queue its report.
  task automatic apply_grid_beat(req_e req, logic [15:0] x, logic [15:0] y);
    int i, j, ni, nj, nx, ny, lim;
    logic       nocc [NumCells];
    logic [7:0] nstale [NumCells];
    cell_report_t rep;
    rep = '0;
    nx = int'($signed(x));
    ny = int'($signed(y));
    case (req)
      REQ_RECENTER: begin
        for (i = 0; i < NumCells; i++) begin
          nocc[i] = 1'b0;
          nstale[i] = 8'd0;
        end
        if (win_ready) begin
          for (j = 0; j < Rows; j++) begin
            for (i = 0; i < Cols; i++) begin
              if (grid_occ[i + j * Cols]) begin
                ni = win_col + i - nx;
                nj = win_row + j - ny;
                if (ni >= 0 && ni < Cols && nj >= 0 && nj < Rows) begin
                  nocc[ni + nj * Cols] = 1'b1;
                  nstale[ni + nj * Cols] = (grid_stale[i + j * Cols] < StaleShiftCap) ?
                      grid_stale[i + j * Cols] + 8'd1 : StaleShiftCap;
                end
              end
            end
          end
        end
        for (i = 0; i < NumCells; i++) begin
          grid_occ[i] = nocc[i];
          grid_stale[i] = nstale[i];
          grid_touch[i] = 1'b0;
        end
        win_col = nx;
        win_row = ny;
        win_ready = 1'b1;
      end
      REQ_DECAY: begin
        lim = (stale_limit == 8'd0) ? 1 : int'(stale_limit);
        if (win_ready) begin
          for (i = 0; i < NumCells; i++) begin
            if (grid_occ[i]) begin
              if (grid_touch[i]) begin
                grid_stale[i] = 8'd0;
              end else begin
                if (grid_stale[i] < StaleMax) grid_stale[i] = grid_stale[i] + 8'd1;
                if (int'(grid_stale[i]) > lim) grid_occ[i] = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        i = nx - win_col;
        j = ny - win_row;
        if (win_ready && i >= 0 && i < Cols && j >= 0 && j < Rows) begin
          if (req == REQ_HIT) begin
            grid_occ[i + j * Cols] = 1'b1;
            grid_stale[i + j * Cols] = 8'd0;
            grid_touch[i + j * Cols] = 1'b1;
          end
          rep.in_window = 1'b1;
          rep.occupied = grid_occ[i + j * Cols];
          rep.stale_count = grid_stale[i + j * Cols];
        end
      end
    endcase
    pending_reports.insert(pending_reports.size(), rep);
  endtask

  // Offer one beat; entered and left just after a rising edge.
  task automatic send_beat(req_e req, logic [15:0] x, logic [15:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    cell_x_i   <= x;
    cell_y_i   <= y;
    do @(posedge clk_i); while (!in_ready_o);
    apply_grid_beat(req, x, y);
  endtask

  // Drop valid and wait until every queued report has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the staleness limit while the block is idle.
  task automatic write_stale_limit(logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stale_limit = value;
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Hits, decay and reads before the grid has a window.
  task automatic test_not_ready();
    send_beat(REQ_READ, 16'd0, 16'd0);
    send_beat(REQ_HIT, 16'd5, 16'd5);
    send_beat(REQ_DECAY, 16'hFFFF, 16'h0000);
    send_beat(REQ_READ, 16'd5, 16'd5);
  endtask

  // Windows at both ends of the coordinate range and the window edges.
  task automatic test_extremes();
    send_beat(REQ_RECENTER, 16'h8000, 16'h8000);
    send_beat(REQ_HIT, 16'h8000, 16'h8000);
    send_beat(REQ_HIT, 16'h803F, 16'h803F);
    send_beat(REQ_READ, 16'h8040, 16'h8000);
    send_beat(REQ_READ, 16'h7FFF, 16'h8000);
    send_beat(REQ_HIT, 16'h8000, 16'h8040);
    send_beat(REQ_RECENTER, 16'h8001, 16'h8001);
    send_beat(REQ_READ, 16'h803F, 16'h803F);
    send_beat(REQ_READ, 16'h8000, 16'h8000);
    send_beat(REQ_RECENTER, 16'h7FFF, 16'h7FFF);
    send_beat(REQ_HIT, 16'h7FFF, 16'h7FFF);
    send_beat(REQ_READ, 16'h7FFF, 16'h7FFF);
    send_beat(REQ_READ, 16'h7FFE, 16'h7FFF);
  endtask

  // Aging, freeing and the reset of touched cells by a sweep.
  task automatic test_decay();
    write_stale_limit(8'd1);
    send_beat(REQ_RECENTER, 16'd0, 16'd0);
    send_beat(REQ_HIT, 16'd3, 16'd4);
    send_beat(REQ_HIT, 16'd63, 16'd63);
    send_beat(REQ_DECAY, 16'd0, 16'd0);
    send_beat(REQ_READ, 16'd3, 16'd4);
    send_beat(REQ_RECENTER, 16'd0, 16'd0);
    send_beat(REQ_READ, 16'd3, 16'd4);
    send_beat(REQ_DECAY, 16'd0, 16'd0);
    send_beat(REQ_READ, 16'd63, 16'd63);
    write_stale_limit(8'd0);
    send_beat(REQ_HIT, 16'd1, 16'd1);
    send_beat(REQ_RECENTER, 16'd0, 16'd0);
    send_beat(REQ_DECAY, 16'd0, 16'd0);
    send_beat(REQ_READ, 16'd1, 16'd1);
  endtask

  // Long receiver stall while beats keep coming, then a full drain.
  task automatic test_backpressure();
    int n;
    hold_req = 1'b1;
    for (n = 0; n < 20; n++) begin
      send_beat($urandom_range(0, 1) ? REQ_HIT : REQ_READ,
                16'(win_col + $urandom_range(0, 63)), 16'(win_row + $urandom_range(0, 63)));
    end
    wait_drained();
  endtask

  // Random traffic near a roaming window, with rare sweeps and wild coordinates.
  task automatic test_random(int count, logic [7:0] limit);
    int n, pick, base_x, base_y;
    logic [15:0] x, y;
    write_stale_limit(limit);
    base_x = $urandom_range(0, 65535) - 32768;
    base_y = $urandom_range(0, 65535) - 32768;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        x = 16'(base_x + $urandom_range(0, 24) - 12);
        y = 16'(base_y + $urandom_range(0, 24) - 12);
        send_beat(REQ_RECENTER, x, y);
      end else if (pick < 5) begin
        send_beat(REQ_DECAY, 16'($urandom), 16'($urandom));
      end else if (pick < 10) begin
        send_beat($urandom_range(0, 1) ? REQ_HIT : REQ_READ, 16'($urandom), 16'($urandom));
      end else begin
        x = 16'(win_col + $urandom_range(0, 79) - 8);
        y = 16'(win_row + $urandom_range(0, 79) - 8);
        send_beat(pick < 55 ? REQ_HIT : REQ_READ, x, y);
      end
    end
  endtask

  // Receiver: shifting ready patterns plus an on-demand long hold.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(50, 300);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare every output beat with the oldest queued report.
  always @(posedge clk_i) begin
    cell_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("output beat with no report pending");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (in_window_o !== want.in_window)
          report_mismatch("in_window", in_window_o, want.in_window);
        if (occupied_o !== want.occupied)
          report_mismatch("occupied", occupied_o, want.occupied);
        if (stale_count_o !== want.stale_count)
          report_mismatch("stale_count", stale_count_o, want.stale_count);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    int k;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'd0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_READ;
    cell_x_i    = '0;
    cell_y_i    = '0;
    fail_count  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    for (k = 0; k < NumCells; k++) begin
      grid_occ[k] = 1'b0;
      grid_stale[k] = 8'd0;
      grid_touch[k] = 1'b0;
    end
    win_col = 0;
    win_row = 0;
    win_ready = 1'b0;
    stale_limit = StaleLimRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_not_ready();
    test_extremes();
    test_decay();
    test_backpressure();
    test_random(300, StaleLimRst);
    test_random(250, 8'd255);
    test_backpressure();
    test_random(250, 8'd1);
    test_random(250, 8'($urandom_range(2, 254)));
    test_random(250, 8'($urandom_range(1, 6)));

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
